// ===== rtl/ccb_pkg.sv =====
`timescale 1ns / 1ps
package ccb_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int NUM_SURFACES = 2;
   localparam int PLANE        = MAX_WIDTH * MAX_HEIGHT;
   localparam int PLANE_AW     = $clog2(PLANE);
   localparam int SURF_AW      = $clog2(NUM_SURFACES);
   localparam int DIM_W        = 11;
   localparam int CNT_W        = 21;
   localparam int REQ_DATA_W   = 72;
   localparam int REQ_USER_W   = 6;
   localparam int RSP_DATA_W   = 32;
   localparam int CSR_IDX_W    = 3;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_BLIT  = 2'd2,
      OP_FILL  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SURF0_WIDTH  = 3'd0,
      CSR_SURF0_HEIGHT = 3'd1,
      CSR_SURF1_WIDTH  = 3'd2,
      CSR_SURF1_HEIGHT = 3'd3,
      CSR_UNKEYED      = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PIX,
      ST_SNAP,
      ST_BLIT,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic pix_go;
      logic snap_step;
      logic blit_step;
      logic fill_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   snap_more;
      logic   blit_more;
      logic   fill_more;
   } sts_type;

endpackage

// ===== rtl/clipped_color_key_blitter_unit.sv =====
`timescale 1ns / 1ps
// Pixel engine with two 8-bit surfaces. Each request word is handled to completion
// before the next is taken, but a finished response may wait in the output register
// while the next request is accepted. A pixel write or read passes the setup, pixel
// and done states after acceptance. A blit passes setup, then copies the W*H source
// surface into the snapshot memory one pixel per cycle, then copies the w*h clipped
// rectangle one pixel per cycle through the snapshot read port, then done. A fill
// steps once per stored pixel and once more per row. The done state of every item
// waits while the previous response is unread.
module clipped_color_key_blitter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ccb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ccb_pkg::DIM_W-1:0]            csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x, pos_y, rect_width, rect_height, dest_x, dest_y, pixel_value, zero pad
   input  logic [ccb_pkg::REQ_DATA_W-1:0]       req_tdata,
   // op, src_surface, dst_surface, key_request, whole_surface
   input  logic [ccb_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // read_data, pixels_written, zero pad
   output logic [ccb_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import ccb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ccb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ccb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/ccb_ctrl.sv =====
`timescale 1ns / 1ps
module ccb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ccb_pkg::sts_type  sts,
   output ccb_pkg::cmd_type  cmd
);
   import ccb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            case (sts.op)
               OP_BLIT: state_in = ST_SNAP;
               OP_FILL: state_in = ST_FILL;
               default: state_in = ST_PIX;
            endcase
         end
         ST_PIX: begin
            cmd.pix_go = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SNAP: begin
            if (sts.snap_more) begin
               cmd.snap_step = 1'b1;
            end else begin
               state_in = ST_BLIT;
            end
         end
         ST_BLIT: begin
            if (sts.blit_more) begin
               cmd.blit_step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            if (sts.fill_more) begin
               cmd.fill_step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/ccb_datapath.sv =====
`timescale 1ns / 1ps
module ccb_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ccb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccb_pkg::DIM_W-1:0]        csr_wdata,
   input  logic [ccb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [ccb_pkg::REQ_USER_W-1:0]   req_tuser,
   input  ccb_pkg::cmd_type                 cmd,
   output ccb_pkg::sts_type                 sts,
   output logic [ccb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ccb_pkg::*;

   localparam int AW = SURF_AW + PLANE_AW;
   localparam int BW = 2 * DIM_W;

   function automatic logic [DIM_W-1:0] sat_w(input logic [DIM_W-1:0] v);
      sat_w = (v > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : v;
   endfunction

   function automatic logic [DIM_W-1:0] sat_h(input logic [DIM_W-1:0] v);
      sat_h = (v > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : v;
   endfunction

   function automatic logic [DIM_W-1:0] min3(input logic [DIM_W-1:0] a,
                                             input logic [DIM_W-1:0] b,
                                             input logic [DIM_W-1:0] c);
      logic [DIM_W-1:0] m;
      m    = (a < b) ? a : b;
      min3 = (m < c) ? m : c;
   endfunction

   logic [DIM_W-1:0] s0w_ff, s0h_ff, s1w_ff, s1h_ff, unkey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0w_ff   <= DIM_W'(640);
         s0h_ff   <= DIM_W'(480);
         s1w_ff   <= DIM_W'(640);
         s1h_ff   <= DIM_W'(480);
         unkey_ff <= DIM_W'(640);
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SURF0_WIDTH:  s0w_ff   <= csr_wdata;
            CSR_SURF0_HEIGHT: s0h_ff   <= csr_wdata;
            CSR_SURF1_WIDTH:  s1w_ff   <= csr_wdata;
            CSR_SURF1_HEIGHT: s1h_ff   <= csr_wdata;
            CSR_UNKEYED:      unkey_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   op_type               op_ff;
   logic [SURF_AW-1:0]   src_ff, dst_ff;
   logic [9:0]           px_ff, py_ff, dx_ff, dy_ff;
   logic [DIM_W-1:0]     rw_ff, rh_ff;
   logic [7:0]           val_ff;
   logic                 key_ff, whole_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_tuser[1:0]);
         src_ff   <= SURF_AW'(req_tuser[2]);
         dst_ff   <= SURF_AW'(req_tuser[3]);
         key_ff   <= req_tuser[4];
         whole_ff <= req_tuser[5];
         px_ff    <= req_tdata[9:0];
         py_ff    <= req_tdata[19:10];
         rw_ff    <= req_tdata[30:20];
         rh_ff    <= req_tdata[41:31];
         dx_ff    <= req_tdata[51:42];
         dy_ff    <= req_tdata[61:52];
         val_ff   <= req_tdata[69:62];
      end
   end

   logic [DIM_W-1:0] sw, sh, dw, dh, bx, by, brw, brh, fx, fy, frw, frh;
   logic [DIM_W-1:0] pxe, pye, dxe, dye, ni_c, nj_c;
   logic [DIM_W-1:0] ma_x, ma_y, mc_x, mc_y;

   always_comb begin
      sw   = sat_w(src_ff != '0 ? s1w_ff : s0w_ff);
      sh   = sat_h(src_ff != '0 ? s1h_ff : s0h_ff);
      dw   = sat_w(dst_ff != '0 ? s1w_ff : s0w_ff);
      dh   = sat_h(dst_ff != '0 ? s1h_ff : s0h_ff);
      pxe  = DIM_W'(px_ff);
      pye  = DIM_W'(py_ff);
      dxe  = DIM_W'(dx_ff);
      dye  = DIM_W'(dy_ff);
      bx   = whole_ff ? '0 : pxe;
      by   = whole_ff ? '0 : pye;
      brw  = whole_ff ? sw : rw_ff;
      brh  = whole_ff ? sh : rh_ff;
      fx   = whole_ff ? '0 : pxe;
      fy   = whole_ff ? '0 : pye;
      frw  = whole_ff ? dw : rw_ff;
      frh  = whole_ff ? dh : rh_ff;
      ni_c = (bx < sw && dxe < dw) ? min3(brw, sw - bx, dw - dxe) : '0;
      nj_c = (by < sh && dye < dh) ? min3(brh, sh - by, dh - dye) : '0;
      case (op_ff)
         OP_BLIT: begin
            ma_x = by;
            ma_y = sw;
            mc_x = sw;
            mc_y = sh;
         end
         OP_FILL: begin
            ma_x = fy;
            ma_y = dw;
            mc_x = dw;
            mc_y = dh;
         end
         default: begin
            ma_x = pye;
            ma_y = dw;
            mc_x = dw;
            mc_y = dh;
         end
      endcase
   end

   logic [BW-1:0]    base_a_ff, base_a_in;
   logic [CNT_W-1:0] base_b_ff, base_b_in;
   logic [CNT_W-1:0] prod_c_ff;
   logic [DIM_W-1:0] cx_ff, wid_ff, hgt_ff, step_ff, dw_ff;
   logic             keyed_ff, pix_ok_ff;
   logic [DIM_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] lin_ff, lin_in, count_ff, count_in;
   logic             snap_pend_ff, blit_pend_ff;
   logic [PLANE_AW-1:0] snap_waddr_ff;
   logic [AW-1:0]       blit_waddr_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         prod_c_ff <= CNT_W'(mc_x * mc_y);
         keyed_ff  <= key_ff && (brw != unkey_ff);
         pix_ok_ff <= (pxe < dw) && (pye < dh);
         dw_ff     <= dw;
         cx_ff     <= (op_ff == OP_BLIT) ? bx : fx;
         wid_ff    <= (op_ff == OP_BLIT) ? ni_c : frw;
         hgt_ff    <= (op_ff == OP_BLIT) ? nj_c : frh;
         step_ff   <= (op_ff == OP_BLIT) ? sw : dw;
      end
   end

   always_ff @(posedge clock) begin
      base_a_ff     <= base_a_in;
      base_b_ff     <= cmd.setup ? CNT_W'(dye * dw) : base_b_in;
      snap_waddr_ff <= lin_ff[PLANE_AW-1:0];
      i_ff          <= i_in;
      j_ff          <= j_in;
      lin_ff        <= lin_in;
      count_ff      <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_pend_ff <= 1'b0;
         blit_pend_ff <= 1'b0;
      end else begin
         snap_pend_ff <= cmd.snap_step;
         blit_pend_ff <= cmd.blit_step;
      end
   end

   logic [7:0]          surf_mem [0:NUM_SURFACES*PLANE-1];
   logic [7:0]          snap_mem [0:PLANE-1];
   logic [7:0]          surf_q, snap_q;
   logic [AW-1:0]       surf_raddr, surf_waddr;
   logic [7:0]          surf_wdata;
   logic                surf_we;
   logic [PLANE_AW-1:0] snap_raddr, pix_addr, src_addr, dst_addr;
   logic [BW-1:0]       fill_idx;
   logic                row_ok, inner_ok, blit_wr;

   always_comb begin
      pix_addr   = PLANE_AW'(base_a_ff) + PLANE_AW'(px_ff);
      src_addr   = PLANE_AW'(base_a_ff) + PLANE_AW'(cx_ff) + PLANE_AW'(i_ff);
      dst_addr   = PLANE_AW'(base_b_ff) + PLANE_AW'(dx_ff) + PLANE_AW'(i_ff);
      fill_idx   = base_a_ff + BW'(cx_ff) + BW'(i_ff);
      row_ok     = (j_ff < hgt_ff) && (base_a_ff < BW'(prod_c_ff));
      inner_ok   = (i_ff < wid_ff) && (fill_idx < BW'(prod_c_ff));
      blit_wr    = blit_pend_ff && ((snap_q != 8'd0) || !keyed_ff);
      snap_raddr = src_addr;
      surf_raddr = cmd.snap_step ? {src_ff, lin_ff[PLANE_AW-1:0]} : {dst_ff, pix_addr};

      surf_we    = 1'b0;
      surf_waddr = {dst_ff, pix_addr};
      surf_wdata = val_ff;
      if (blit_wr) begin
         surf_we    = 1'b1;
         surf_waddr = blit_waddr_ff;
         surf_wdata = snap_q;
      end else if (cmd.fill_step && inner_ok) begin
         surf_we    = 1'b1;
         surf_waddr = {dst_ff, fill_idx[PLANE_AW-1:0]};
      end else if (cmd.pix_go && op_ff == OP_WRITE && pix_ok_ff) begin
         surf_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (surf_we) begin
         surf_mem[surf_waddr] <= surf_wdata;
      end
      surf_q <= surf_mem[surf_raddr];
   end

   always_ff @(posedge clock) begin
      if (snap_pend_ff) begin
         snap_mem[snap_waddr_ff] <= surf_q;
      end
      snap_q <= snap_mem[snap_raddr];
      if (cmd.blit_step) begin
         blit_waddr_ff <= {dst_ff, dst_addr};
      end
   end

   always_comb begin
      base_a_in = base_a_ff;
      base_b_in = base_b_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      lin_in    = lin_ff;
      count_in  = count_ff;
      if (cmd.setup) begin
         base_a_in = BW'(ma_x * ma_y);
         i_in      = '0;
         j_in      = '0;
         lin_in    = '0;
         count_in  = '0;
      end
      if (cmd.snap_step) begin
         lin_in = lin_ff + CNT_W'(1);
      end
      if (cmd.blit_step) begin
         if (i_ff + DIM_W'(1) == wid_ff) begin
            i_in      = '0;
            j_in      = j_ff + DIM_W'(1);
            base_a_in = base_a_ff + BW'(step_ff);
            base_b_in = base_b_ff + CNT_W'(dw_ff);
         end else begin
            i_in = i_ff + DIM_W'(1);
         end
      end
      if (cmd.fill_step) begin
         if (inner_ok) begin
            i_in     = i_ff + DIM_W'(1);
            count_in = count_ff + CNT_W'(1);
         end else begin
            i_in      = '0;
            j_in      = j_ff + DIM_W'(1);
            base_a_in = base_a_ff + BW'(dw_ff);
         end
      end
      if (blit_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pix_go && op_ff == OP_WRITE && pix_ok_ff) begin
         count_in = CNT_W'(1);
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.snap_more = lin_ff < prod_c_ff;
      sts.blit_more = (wid_ff != '0) && (j_ff < hgt_ff);
      sts.fill_more = row_ok;
   end

   logic [7:0]       rsp_read_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_read_ff  <= (op_ff == OP_READ && pix_ok_ff) ? surf_q : 8'd0;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_tdata = {3'b000, rsp_count_ff, rsp_read_ff};

endmodule

// ===== rtl/ccb_checker.sv =====
`timescale 1ns / 1ps
module ccb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [ccb_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import ccb_pkg::*;

   // A response word that is held back keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Once a request word is taken, the engine is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken twice in a row");

   // An item passes the setup state and later states before its response is loaded.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared right after acceptance");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind clipped_color_key_blitter_unit ccb_checker u_ccb_checker (.*);
